FILE: hdl/sbx_pkg.sv
package sbx_pkg;

   localparam int MAG_W      = 20;
   localparam int DIVS_W     = 9;
   localparam int SPREAD_W   = 24;
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = MAG_W / DIV_STAGES;
   localparam logic [SPREAD_W-1:0] SPREAD_MAX = 24'hFFFFFF;

   localparam logic CSR_DIST_INDEX = 1'b0;
   localparam logic CSR_CROSS_PROB = 1'b1;

   typedef struct packed {
      logic signed [31:0] parent_a;
      logic signed [31:0] parent_b;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic [15:0]        cross_draw;
      logic [15:0]        spread_draw;
      logic               last_gene_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] child_a;
      logic signed [31:0] child_b;
      logic               crossed;
      logic               last_gene_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] parent_a;
      logic signed [31:0] parent_b;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic               crossed;
      logic               last_gene;
   } gene_type;

   typedef struct packed {
      logic [DIVS_W-1:0] rem;
      logic [MAG_W-1:0]  dq;
      logic [DIVS_W-1:0] dvs;
      logic              neg;
      logic              zero;
   } div_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bt;
      logic [63:0] vv;
      res = '0;
      vv  = v;
      bt  = 64'd1 << 62;
      while (bt > vv) bt = bt >> 2;
      while (bt != 0) begin
         if (vv >= res + bt) begin
            vv  = vv - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] log_entry(input int i, input int ltb);
      logic [63:0] x;
      logic [15:0] r;
      x = ((64'd1 << ltb) + 64'(i)) << (30 - ltb);
      r = '0;
      for (int k = 0; k < 16; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (64'd2 << 30)) begin
            x    = x >> 1;
            r[0] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [30:0] exp_entry(input int i, input int ltb);
      logic [63:0] roots [0:12];
      logic [63:0] m;
      roots[0] = 64'd2 << 30;
      for (int k = 1; k <= 12; k++) roots[k] = isqrt64(roots[k-1] << 30);
      m = 64'd1 << 30;
      for (int j = 0; j < ltb; j++)
         if (((i >> j) & 1) != 0) m = (m * roots[ltb - j]) >> 30;
      return m[30:0];
   endfunction

endpackage

FILE: hdl/sbx_div_step.sv
module sbx_div_step #(
   parameter int STEPS = 5
) (
   input  logic             clock,
   input  logic             adv,
   input  sbx_pkg::div_type st_in,
   output sbx_pkg::div_type st_out
);

   sbx_pkg::div_type st_in_c;
   sbx_pkg::div_type st_ff;

   always_comb begin
      logic [sbx_pkg::DIVS_W:0] r;
      st_in_c = st_in;
      for (int k = 0; k < STEPS; k++) begin
         r = {st_in_c.rem, st_in_c.dq[sbx_pkg::MAG_W-1]};
         st_in_c.dq = st_in_c.dq << 1;
         if (r >= {1'b0, st_in_c.dvs}) begin
            r = r - {1'b0, st_in_c.dvs};
            st_in_c.dq[0] = 1'b1;
         end
         st_in_c.rem = r[sbx_pkg::DIVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) st_ff <= st_in_c;
   end

   assign st_out = st_ff;

endmodule

FILE: hdl/sbx_spread.sv
module sbx_spread #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [15:0]                   spread_draw,
   input  logic [7:0]                    div_index,
   output logic [sbx_pkg::SPREAD_W-1:0]  spread
);

   localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;

   logic [15:0] log_tab [TAB_SIZE];
   logic [30:0] exp_tab [TAB_SIZE];

   for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_tab
      assign log_tab[gi] = sbx_pkg::log_entry(gi, LOG_TABLE_BITS);
      assign exp_tab[gi] = sbx_pkg::exp_entry(gi, LOG_TABLE_BITS);
   end

   // log stage: magnitude of log2 of 2u or 2(1-u), both reduce to the same form
   logic [16:0]              w;
   logic [3:0]               pos;
   logic [15:0]              norm;
   logic [LOG_TABLE_BITS-1:0] lidx;
   sbx_pkg::div_type         st0_in;
   sbx_pkg::div_type         st_ff [sbx_pkg::DIV_STAGES+1];

   always_comb begin
      w = spread_draw[15] ? (17'h10000 - {1'b0, spread_draw}) : {1'b0, spread_draw};
      pos = '0;
      for (int k = 0; k < 16; k++)
         if (w[k]) pos = 4'(k);
      norm = w[15:0] << (4'd15 - pos);
      lidx = norm[14 -: LOG_TABLE_BITS];
      st0_in.rem  = '0;
      st0_in.dq   = {(4'd15 - pos), 16'h0000} - {4'b0000, log_tab[lidx]};
      st0_in.dvs  = {1'b0, div_index} + 9'd1;
      st0_in.neg  = ~spread_draw[15];
      st0_in.zero = (spread_draw == 16'h0000);
   end

   always_ff @(posedge clock) begin
      if (adv) st_ff[0] <= st0_in;
   end

   for (genvar gs = 0; gs < sbx_pkg::DIV_STAGES; gs++) begin : g_div
      sbx_div_step #(.STEPS(sbx_pkg::DIV_STEPS)) u_step (
         .clock  (clock),
         .adv    (adv),
         .st_in  (st_ff[gs]),
         .st_out (st_ff[gs+1])
      );
   end

   // exp stage
   sbx_pkg::div_type            qst;
   logic signed [20:0]          e;
   logic signed [4:0]           ip;
   logic [5:0]                  sh;
   logic [30:0]                 mant;
   logic [sbx_pkg::SPREAD_W-1:0] spread_in;
   logic [sbx_pkg::SPREAD_W-1:0] spread_ff;

   always_comb begin
      qst  = st_ff[sbx_pkg::DIV_STAGES];
      e    = qst.neg ? -$signed({1'b0, qst.dq}) : $signed({1'b0, qst.dq});
      ip   = e[20:16];
      sh   = 6'd14 - {ip[4], ip};
      mant = exp_tab[e[15 -: LOG_TABLE_BITS]] >> sh;
      if (qst.zero)
         spread_in = '0;
      else if (!ip[4] && ip[3])
         spread_in = sbx_pkg::SPREAD_MAX;
      else if (mant > {7'd0, sbx_pkg::SPREAD_MAX})
         spread_in = sbx_pkg::SPREAD_MAX;
      else
         spread_in = mant[sbx_pkg::SPREAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) spread_ff <= spread_in;
   end

   assign spread = spread_ff;

endmodule

FILE: hdl/sbx_blend.sv
module sbx_blend (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [sbx_pkg::SPREAD_W-1:0]  spread,
   input  sbx_pkg::gene_type             gene,
   output sbx_pkg::rsp_type              rsp
);

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      if (v > 42'sd2147483647)       return 32'sh7FFFFFFF;
      else if (v < -42'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   // multiply stage: p = 2^16*(a+b) +/- s*(a-b)
   sbx_pkg::gene_type  g1_ff;
   logic signed [57:0] prod_ff;
   logic signed [48:0] base_ff;
   logic signed [32:0] diff;
   logic signed [32:0] sum;

   assign diff = 33'(gene.parent_a) - 33'(gene.parent_b);
   assign sum  = 33'(gene.parent_a) + 33'(gene.parent_b);

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_ff   <= gene;
         prod_ff <= 58'($signed({1'b0, spread})) * 58'(diff);
         base_ff <= {sum, 16'h0000};
      end
   end

   // sum, floor shift and saturate
   sbx_pkg::gene_type  g2_ff;
   logic signed [31:0] ca_ff;
   logic signed [31:0] cb_ff;
   logic signed [58:0] pa;
   logic signed [58:0] pb;
   logic signed [41:0] qa;
   logic signed [41:0] qb;

   always_comb begin
      pa = 59'(base_ff) + 59'(prod_ff);
      pb = 59'(base_ff) - 59'(prod_ff);
      qa = 42'(pa >>> 17);
      qb = 42'(pb >>> 17);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g2_ff <= g1_ff;
         ca_ff <= sat32(qa);
         cb_ff <= sat32(qb);
      end
   end

   // clamp: lower bound first, then upper
   function automatic logic signed [31:0] clamp(input logic signed [31:0] c,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = c;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   sbx_pkg::rsp_type rsp_in;
   sbx_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_in.crossed       = g2_ff.crossed;
      rsp_in.last_gene_out = g2_ff.last_gene;
      if (g2_ff.crossed) begin
         rsp_in.child_a = clamp(ca_ff, g2_ff.lower_bound, g2_ff.upper_bound);
         rsp_in.child_b = clamp(cb_ff, g2_ff.lower_bound, g2_ff.upper_bound);
      end else begin
         rsp_in.child_a = g2_ff.parent_a;
         rsp_in.child_b = g2_ff.parent_b;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

FILE: hdl/sbx_crossover_gene.sv
// SBX crossover of one gene pair per transfer.
// Request channel (req_valid/req_stall/req_payload): parents, bounds and the
// two uniform draws. Response channel (rsp_valid/rsp_stall/rsp_payload): the
// two children, the crossed flag and the last-gene marker.
// Configuration: csr_wr_en with csr_index 0 writes the distribution index,
// index 1 the crossing probability; write only while the pipeline is empty.
// The path from request transfer to response valid: one log stage,
// four stages of a restoring divider (5 quotient bits each) for 1/(n+1),
// one exp2 stage, then multiply, sum/saturate and clamp stages.
// One gene per cycle while no response stalls; every stage holds one item.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and loads the register defaults
// (distribution index 2, probability 58982).
module sbx_crossover_gene #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbx_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbx_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [16:0]      csr_wdata
);

   localparam int LAT      = 9;
   localparam int LINE_LEN = 6;

   logic [7:0]  dist_index_ff;
   logic [16:0] cross_prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_index_ff <= 8'd2;
         cross_prob_ff <= 17'd58982;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sbx_pkg::CSR_DIST_INDEX: dist_index_ff <= csr_wdata[7:0];
            sbx_pkg::CSR_CROSS_PROB: cross_prob_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv       = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset)    vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   assign rsp_valid = vld_ff[LAT-1];

   // hold the gene alongside the spread computation
   sbx_pkg::gene_type gene_in;
   sbx_pkg::gene_type line_ff [LINE_LEN];

   always_comb begin
      gene_in.parent_a    = req_payload.parent_a;
      gene_in.parent_b    = req_payload.parent_b;
      gene_in.lower_bound = req_payload.lower_bound;
      gene_in.upper_bound = req_payload.upper_bound;
      gene_in.crossed     = ({1'b0, req_payload.cross_draw} < cross_prob_ff);
      gene_in.last_gene   = req_payload.last_gene_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= gene_in;
         for (int k = 1; k < LINE_LEN; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   logic [sbx_pkg::SPREAD_W-1:0] spread;

   sbx_spread #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_spread (
      .clock       (clock),
      .adv         (adv),
      .spread_draw (req_payload.spread_draw),
      .div_index   (dist_index_ff),
      .spread      (spread)
   );

   sbx_blend u_blend (
      .clock  (clock),
      .adv    (adv),
      .spread (spread),
      .gene   (line_ff[LINE_LEN-1]),
      .rsp    (rsp_payload)
   );

endmodule

FILE: hdl/sbx_checker.sv
module sbx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sbx_pkg::rsp_type rsp_payload
);

   // pipeline comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // input only backs up behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_payload))
      else $error("stalled response payload changed");

endmodule

bind sbx_crossover_gene sbx_checker u_sbx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
